### rtl/key_value_line_tokenizer_macros.svh
// Assertion macros for the key/value line tokenizer.
// Used by the top level only; expects clk and rst in scope.
`ifndef KEY_VALUE_LINE_TOKENIZER_MACROS_SVH
`define KEY_VALUE_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define KVLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KVLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/kvlt_pkg.sv
// Shared types and constants for the key/value line tokenizer.
// No dependencies.
package kvlt_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 128;

  localparam logic [15:0] CU_NUL         = 16'h0000;
  localparam logic [15:0] CU_TAB         = 16'h0009;
  localparam logic [15:0] CU_LF          = 16'h000A;
  localparam logic [15:0] CU_CR          = 16'h000D;
  localparam logic [15:0] CU_SPACE       = 16'h0020;
  localparam logic [15:0] CU_BOM         = 16'hFEFF;
  localparam logic [15:0] CU_BOM_SWAPPED = 16'hFFFE;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_KEY_CHAR  = 3'd1;
  localparam logic [2:0] EV_KEY_END   = 3'd2;
  localparam logic [2:0] EV_VAL_CHAR  = 3'd3;
  localparam logic [2:0] EV_ENTRY_END = 3'd4;
  localparam logic [2:0] EV_EOT       = 3'd5;
  localparam logic [2:0] EV_ERROR     = 3'd6;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_LONE_LF     = 4'd1;
  localparam logic [3:0] ERR_BLANK_CR    = 4'd2;
  localparam logic [3:0] ERR_EOT_KEY     = 4'd3;
  localparam logic [3:0] ERR_EOL_KEY     = 4'd4;
  localparam logic [3:0] ERR_KEY_LONG    = 4'd5;
  localparam logic [3:0] ERR_EOT_PRE_VAL = 4'd6;
  localparam logic [3:0] ERR_EOL_PRE_VAL = 4'd7;
  localparam logic [3:0] ERR_VAL_LONG    = 4'd8;
  localparam logic [3:0] ERR_BE_BOM      = 4'd9;

  localparam logic [1:0] WARN_NONE    = 2'd0;
  localparam logic [1:0] WARN_LONE_LF = 2'd1;
  localparam logic [1:0] WARN_LONE_CR = 2'd2;

  typedef enum logic [8:0] {
    PH_START     = 9'b000000001,
    PH_AFTER_BOM = 9'b000000010,
    PH_LOOK_KEY  = 9'b000000100,
    PH_BLANK_CR  = 9'b000001000,
    PH_KEY       = 9'b000010000,
    PH_LOOK_VAL  = 9'b000100000,
    PH_VAL       = 9'b001000000,
    PH_VAL_CR    = 9'b010000000,
    PH_HALT      = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] ch;
    logic [6:0]  idx;
    logic [3:0]  err;
    logic [1:0]  warn;
  } result_t;

  function automatic logic is_blank(input logic [15:0] u);
    return (u == CU_TAB) || (u == CU_SPACE);
  endfunction

endpackage

### rtl/key_value_line_tokenizer.sv
// Top level of the key/value line tokenizer: input register, step logic, result register.
// Depends on kvlt_pkg, kvlt_core and key_value_line_tokenizer_macros.svh.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  in      | in_valid  | in_stall  | code_unit
//  out     | out_valid | out_stall | event_res, char_out, char_index,
//          |           |           | error_code, warning
//
// One item per cycle sustained while out_stall is low. An accepted item waits in the
// input register, then moves to the result register, where its result is offered.
// Each item gives exactly one result; the phase updates as it enters the result register.
// Synchronous reset returns to the start phase, expecting an optional byte-order mark.
// in_stall rises only when both the input and the result registers hold an item and
// out_stall is high.
`include "key_value_line_tokenizer_macros.svh"

module key_value_line_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = kvlt_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] code_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [15:0] char_out,
  output logic [6:0]  char_index,
  output logic [3:0]  error_code,
  output logic [1:0]  warning
);
  import kvlt_pkg::*;

  logic        s1_valid;
  logic [15:0] s1_unit;
  logic        out_free;
  logic        advance;
  logic        take_in;
  result_t     step_res;
  result_t     out_res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign take_in  = in_valid && !in_stall;

  kvlt_core #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .unit(s1_unit),
    .res (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_unit <= code_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign event_res  = out_res.ev;
  assign char_out   = out_res.ch;
  assign char_index = out_res.idx;
  assign error_code = out_res.err;
  assign warning    = out_res.warn;

  `KVLT_ASSERT_NOW(a_char_only_on_char,
    out_valid && event_res != EV_KEY_CHAR && event_res != EV_VAL_CHAR,
    char_out == 16'h0000 && char_index == 7'd0,
    "character fields set on a non-character event")
  `KVLT_ASSERT_NOW(a_err_only_on_error,
    out_valid && error_code != ERR_NONE,
    event_res == EV_ERROR,
    "error code without error event")
  `KVLT_ASSERT_NOW(a_lf_warn_on_entry_end,
    out_valid && warning == WARN_LONE_LF,
    event_res == EV_ENTRY_END,
    "lone LF warning outside entry end")
  `KVLT_ASSERT_NEXT(a_held_item_kept,
    s1_valid && !out_free,
    s1_valid && $stable(s1_unit),
    "held input item lost or changed")

endmodule

### rtl/kvlt_core.sv
// Tokenizer state (phase, token length) and per-item step logic.
// Depends on kvlt_pkg.
module kvlt_core #(
  parameter int unsigned MAX_TOKEN_LEN = kvlt_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [15:0]       unit,
  output kvlt_pkg::result_t res
);
  import kvlt_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned EXT_W = (LEN_W > 7) ? LEN_W : 7;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] token_length, token_length_next;
  logic [EXT_W-1:0] len_ext;
  logic             lk;
  logic [1:0]       lk_warn;
  logic             len_full;

  assign len_ext  = EXT_W'(token_length);
  assign len_full = (token_length >= LEN_MAX);

  always_comb begin
    phase_next        = phase;
    token_length_next = token_length;
    res               = '0;
    lk                = 1'b0;
    lk_warn           = WARN_NONE;
    unique case (phase)
      PH_START: begin
        if (unit == CU_BOM) begin
          phase_next = PH_AFTER_BOM;
        end else if (unit == CU_BOM_SWAPPED) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_BE_BOM;
        end else begin
          lk = 1'b1;
        end
      end
      PH_AFTER_BOM: begin
        if (unit == CU_BOM_SWAPPED) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_BE_BOM;
        end else begin
          lk = 1'b1;
        end
      end
      PH_LOOK_KEY: begin
        lk = 1'b1;
      end
      PH_BLANK_CR: begin
        if (unit == CU_LF) begin
          phase_next = PH_LOOK_KEY;
        end else begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_BLANK_CR;
        end
      end
      PH_KEY: begin
        if (unit == CU_NUL) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_EOT_KEY;
        end else if (is_blank(unit)) begin
          phase_next = PH_LOOK_VAL;
          res.ev     = EV_KEY_END;
        end else if (unit == CU_CR || unit == CU_LF) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_EOL_KEY;
        end else if (len_full) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_KEY_LONG;
        end else begin
          res.ev            = EV_KEY_CHAR;
          res.ch            = unit;
          res.idx           = len_ext[6:0];
          token_length_next = token_length + LEN_ONE;
        end
      end
      PH_LOOK_VAL: begin
        if (unit == CU_NUL) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_EOT_PRE_VAL;
        end else if (is_blank(unit)) begin
          res.ev = EV_NONE;
        end else if (unit == CU_CR || unit == CU_LF) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_EOL_PRE_VAL;
        end else begin
          phase_next        = PH_VAL;
          token_length_next = LEN_ONE;
          res.ev            = EV_VAL_CHAR;
          res.ch            = unit;
        end
      end
      PH_VAL: begin
        if (unit == CU_NUL) begin
          phase_next = PH_HALT;
          res.ev     = EV_ENTRY_END;
        end else if (is_blank(unit)) begin
          res.ev = EV_NONE;
        end else if (unit == CU_LF) begin
          phase_next = PH_LOOK_KEY;
          res.ev     = EV_ENTRY_END;
          res.warn   = WARN_LONE_LF;
        end else if (unit == CU_CR) begin
          phase_next = PH_VAL_CR;
          res.ev     = EV_ENTRY_END;
        end else if (len_full) begin
          phase_next = PH_HALT;
          res.ev     = EV_ERROR;
          res.err    = ERR_VAL_LONG;
        end else begin
          res.ev            = EV_VAL_CHAR;
          res.ch            = unit;
          res.idx           = len_ext[6:0];
          token_length_next = token_length + LEN_ONE;
        end
      end
      PH_VAL_CR: begin
        phase_next = PH_LOOK_KEY;
        if (unit != CU_LF) begin
          lk      = 1'b1;
          lk_warn = WARN_LONE_CR;
        end
      end
      PH_HALT: begin
        res.ev = EV_NONE;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase

    // start-of-line handling, shared by several phases
    if (lk) begin
      res.warn = lk_warn;
      if (unit == CU_NUL) begin
        phase_next = PH_HALT;
        res.ev     = EV_EOT;
      end else if (is_blank(unit)) begin
        res.ev = EV_NONE;
      end else if (unit == CU_LF) begin
        phase_next = PH_HALT;
        res.ev     = EV_ERROR;
        res.err    = ERR_LONE_LF;
      end else if (unit == CU_CR) begin
        phase_next = PH_BLANK_CR;
      end else begin
        phase_next        = PH_KEY;
        token_length_next = LEN_ONE;
        res.ev            = EV_KEY_CHAR;
        res.ch            = unit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      token_length <= '0;
    end else if (step) begin
      phase        <= phase_next;
      token_length <= token_length_next;
    end
  end

endmodule
